// ===== rtl/core/eef_pkg.sv =====
// Package for the edge filter response block: types, register indexes,
// fixed-point constants and the exp2 coefficient function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package eef_pkg;

    localparam int LOG_FRAC = 24;
    localparam int MANT_W   = 31;
    localparam int GAIN_W   = 17;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;
    // exponent saturation: 18 octaves, times 5, in Q.24 (after the /1024)
    localparam logic [31:0] SAT_LIM = 32'd1509949440;
    // floor(y/5) = (y * DIV5_MAGIC) >> 34 for any 32-bit y
    localparam logic [31:0] DIV5_MAGIC = 32'hCCCC_CCCD;

    localparam logic [2:0] CFG_MODE    = 3'd0;
    localparam logic [2:0] CFG_EDGE_LO = 3'd1;
    localparam logic [2:0] CFG_EDGE_HI = 3'd2;
    localparam logic [2:0] CFG_SLOPE_LO = 3'd3;
    localparam logic [2:0] CFG_SLOPE_HI = 3'd4;

    typedef enum logic [1:0] {
        MODE_LOWPASS  = 2'd0,
        MODE_HIGHPASS = 2'd1,
        MODE_BANDPASS = 2'd2,
        MODE_REJECT   = 2'd3
    } t_mode;

    typedef struct packed {
        logic one;
        logic zero;
        logic [4:0] n;
        logic [LOG_FRAC-1:0] r;
    } t_exp_side;

    typedef struct packed {
        logic lt_lo;
        logic gt_lo;
        logic gt_hi;
        logic nz;
    } t_dec;

    // 2^(-2^-k) in Q.30, by repeated integer square roots from 2^29
    function automatic logic [29:0] exp_coef(input int k);
        logic [63:0] c;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        c = 64'd1 << 29;
        for (int i = 1; i <= k; i++) begin
            v   = c << 30;
            res = 64'd0;
            b   = 64'd1 << 62;
            for (int j = 0; j < 32; j++) begin
                if (v >= res + b) begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            c = res;
        end
        return c[29:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/eef_log_cell.sv =====
// One log2 cell: squares the Q.30 mantissa and emits one fraction bit.
// Uses eef_pkg.
`timescale 1ns / 1ps
`default_nettype none

module eef_log_cell
    import eef_pkg::*;
#(
    parameter int PW = 5
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [MANT_W-1:0]   i_m,
    input  wire logic [PW-1:0]       i_p,
    input  wire logic [LOG_FRAC-1:0] i_frac,
    output logic      [MANT_W-1:0]   o_m,
    output logic      [PW-1:0]       o_p,
    output logic      [LOG_FRAC-1:0] o_frac
);

    logic [2*MANT_W-1:0] w_sq;
    logic [MANT_W:0]     w_s;
    logic [MANT_W-1:0]   n_m;
    logic [MANT_W-1:0]   r_m;
    logic [PW-1:0]       r_p;
    logic [LOG_FRAC-1:0] r_frac;

    always_comb begin
        w_sq = {{MANT_W{1'b0}}, i_m} * {{MANT_W{1'b0}}, i_m};
        w_s  = w_sq[2*MANT_W-1:MANT_W-1];
        n_m  = w_s[MANT_W] ? w_s[MANT_W:1] : w_s[MANT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m    <= n_m;
            r_p    <= i_p;
            r_frac <= {i_frac[LOG_FRAC-2:0], w_s[MANT_W]};
        end
    end

    assign o_m    = r_m;
    assign o_p    = r_p;
    assign o_frac = r_frac;

endmodule

`default_nettype wire

// ===== rtl/core/eef_exp_cell.sv =====
// One exp2 cell: applies factor 2^(-2^-K) when its fraction bit is set.
// Uses eef_pkg.
`timescale 1ns / 1ps
`default_nettype none

module eef_exp_cell
    import eef_pkg::*;
#(
    parameter int K = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [MANT_W-1:0] i_g,
    input  wire t_exp_side         i_side,
    output logic      [MANT_W-1:0] o_g,
    output t_exp_side              o_side
);

    localparam logic [29:0] COEF = exp_coef(K);

    logic [MANT_W+29:0] w_prod;
    logic [MANT_W-1:0]  n_g;
    logic [MANT_W-1:0]  r_g;
    t_exp_side          r_side;

    always_comb begin
        w_prod = {30'd0, i_g} * {{MANT_W{1'b0}}, COEF};
        n_g    = i_side.r[LOG_FRAC-K] ? w_prod[MANT_W+29:30] : i_g;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g    <= n_g;
            r_side <= i_side;
        end
    end

    assign o_g    = r_g;
    assign o_side = r_side;

endmodule

`default_nettype wire

// ===== rtl/core/eq_edge_filter_response.sv =====
// Top level of the edge filter response: config registers, log2 and exp2 cell
// chains, edge select and output skid stage. Uses eef_pkg, eef_log_cell, eef_exp_cell.
`timescale 1ns / 1ps
`default_nettype none

// Maps a spectrum bin index to its linear Q1.16 gain for lowpass, highpass,
// bandpass or band reject. One bin is taken every cycle while o_stall is low; the
// path holds two chains of 24 cells (log2 by repeated squaring, exp2 by per-bit
// factors) plus normalize, slope and rounding stages. An output register with one
// skid entry lets input keep flowing while a result waits; o_stall rises only
// when both hold a result. Config is to be written by the user only while no bin
// is in flight; the block does not enforce it. o_cfg_ready is always high.
module eq_edge_filter_response
    import eef_pkg::*;
#(
    parameter int BIN_COUNT   = 1024,
    parameter int TOP_FREQ_HZ = 24000
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [9:0]  i_bin_index,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [16:0]      o_bin_gain,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [14:0] i_cfg_data
);

    localparam int NW  = 10 + $clog2(TOP_FREQ_HZ + 1);
    localparam int DW  = 15 + $clog2(BIN_COUNT + 1);
    localparam int XW0 = (NW > DW) ? NW : DW;
    localparam int XW  = (XW0 > MANT_W) ? XW0 : MANT_W;
    localparam int PW  = $clog2(XW);
    localparam int LW  = PW + LOG_FRAC;
    localparam int PDW = 15 + LW;
    localparam int YW  = PDW - 10;

    localparam int S_NORM  = 1;
    localparam int LOG_END = S_NORM + LOG_FRAC;
    localparam int S_DIFF  = LOG_END + 1;
    localparam int S_Y     = S_DIFF + 1;
    localparam int S_SIDE  = S_Y + 1;
    localparam int EXP_END = S_SIDE + LOG_FRAC;
    localparam int S_RES   = EXP_END + 1;
    localparam int NST     = S_RES + 1;

    // config
    t_mode       r_mode;
    logic [14:0] r_edge_lo;
    logic [14:0] r_edge_hi;
    logic [14:0] r_slope_lo;
    logic [14:0] r_slope_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_LOWPASS;
            r_edge_lo  <= 15'd1000;
            r_edge_hi  <= 15'd4000;
            r_slope_lo <= 15'd0;
            r_slope_hi <= 15'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE:     r_mode     <= t_mode'(i_cfg_data[1:0]);
                CFG_EDGE_LO:  r_edge_lo  <= i_cfg_data;
                CFG_EDGE_HI:  r_edge_hi  <= i_cfg_data;
                CFG_SLOPE_LO: r_slope_lo <= i_cfg_data;
                CFG_SLOPE_HI: r_slope_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    function automatic logic [PW+MANT_W-1:0] norm(input logic [XW-1:0] x);
        logic [PW-1:0] p;
        logic [XW-1:0] y;
        p = '0;
        for (int i = 0; i < XW; i++) begin
            if (x[i]) p = PW'(i);
        end
        y = x << (PW'(XW - 1) - p);
        return {p, y[XW-1 -: MANT_W]};
    endfunction

    function automatic logic [GAIN_W-1:0] round_gain(input logic [MANT_W-1:0] g,
                                                     input logic [4:0] n);
        logic [31:0] sum;
        logic [31:0] sh;
        sum = {1'b0, g} + (32'd1 << (5'd13 + n));
        sh  = sum >> (6'd14 + {1'b0, n});
        return (sh > 32'd65536) ? GAIN_ONE : sh[GAIN_W-1:0];
    endfunction

    logic             w_en;
    logic             r_skid_v;
    logic [NST-1:0]   r_vld;
    t_dec             r_dec [S_NORM:EXP_END];

    assign w_en    = !r_skid_v;
    assign o_stall = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // stage 0: bin frequency numerator
    logic [NW-1:0] r_num;
    always_ff @(posedge i_clk) begin
        if (w_en) r_num <= NW'(i_bin_index) * NW'(TOP_FREQ_HZ);
    end

    // stage 1: normalize all three log operands, frequency compares
    logic [14:0]        w_lo;
    logic [14:0]        w_hi;
    logic [XW-1:0]      w_lo_s;
    logic [XW-1:0]      w_hi_s;
    logic [XW-1:0]      w_num_x;
    logic [PW+MANT_W-1:0] w_nrm [3];
    t_dec               n_dec;

    always_comb begin
        w_lo    = (r_edge_lo == 15'd0) ? 15'd1 : r_edge_lo;
        w_hi    = (r_edge_hi == 15'd0) ? 15'd1 : r_edge_hi;
        w_lo_s  = XW'(DW'(w_lo) * DW'(BIN_COUNT));
        w_hi_s  = XW'(DW'(w_hi) * DW'(BIN_COUNT));
        w_num_x = XW'(r_num);
        w_nrm[0] = norm(w_num_x);
        w_nrm[1] = norm(w_lo_s);
        w_nrm[2] = norm(w_hi_s);
        n_dec.lt_lo = w_num_x < w_lo_s;
        n_dec.gt_lo = w_num_x > w_lo_s;
        n_dec.gt_hi = w_num_x > w_hi_s;
        n_dec.nz    = w_num_x != '0;
    end

    logic [MANT_W-1:0]   w_lm [3][LOG_FRAC+1];
    logic [PW-1:0]       w_lp [3][LOG_FRAC+1];
    logic [LOG_FRAC-1:0] w_lf [3][LOG_FRAC+1];
    logic [MANT_W-1:0]   r_m1 [3];
    logic [PW-1:0]       r_p1 [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r_m1[l] <= w_nrm[l][MANT_W-1:0];
                r_p1[l] <= w_nrm[l][PW+MANT_W-1:MANT_W];
            end
            r_dec[S_NORM] <= n_dec;
            for (int k = S_NORM + 1; k <= EXP_END; k++) r_dec[k] <= r_dec[k-1];
        end
    end

    genvar gl, gk;
    generate
        for (gl = 0; gl < 3; gl++) begin : g_log_lane
            assign w_lm[gl][0] = r_m1[gl];
            assign w_lp[gl][0] = r_p1[gl];
            assign w_lf[gl][0] = '0;
            for (gk = 0; gk < LOG_FRAC; gk++) begin : g_cell
                eef_log_cell #(.PW(PW)) u_cell (
                    .i_clk  (i_clk),
                    .i_en   (w_en),
                    .i_m    (w_lm[gl][gk]),
                    .i_p    (w_lp[gl][gk]),
                    .i_frac (w_lf[gl][gk]),
                    .o_m    (w_lm[gl][gk+1]),
                    .o_p    (w_lp[gl][gk+1]),
                    .o_frac (w_lf[gl][gk+1])
                );
            end
        end
    endgenerate

    // log distance per edge
    logic [LW-1:0] w_ln [3];
    logic [LW-1:0] r_d  [2];
    always_comb begin
        for (int l = 0; l < 3; l++) w_ln[l] = {w_lp[l][LOG_FRAC], w_lf[l][LOG_FRAC]};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int e = 0; e < 2; e++) begin
                r_d[e] <= (w_ln[0] > w_ln[e+1]) ? w_ln[0] - w_ln[e+1] : w_ln[e+1] - w_ln[0];
            end
        end
    end

    // slope times distance, then /1024
    logic [PDW-1:0] w_prod [2];
    logic [YW-1:0]  r_y    [2];
    always_comb begin
        w_prod[0] = PDW'(r_slope_lo) * PDW'(r_d[0]);
        w_prod[1] = PDW'(r_slope_hi) * PDW'(r_d[1]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int e = 0; e < 2; e++) r_y[e] <= w_prod[e][PDW-1:10];
        end
    end

    // /5 split into octaves and fraction
    logic [63:0]       w_q [2];
    t_exp_side         n_side [2];
    t_exp_side         w_side [2][LOG_FRAC+1];
    logic [MANT_W-1:0] w_g    [2][LOG_FRAC+1];
    t_exp_side         r_side [2];

    always_comb begin
        for (int e = 0; e < 2; e++) begin
            w_q[e] = {32'd0, r_y[e][31:0]} * {32'd0, DIV5_MAGIC};
            n_side[e].n    = w_q[e][34+28:34+24];
            n_side[e].r    = w_q[e][34+23:34];
            n_side[e].one  = (e == 0) ? (r_slope_lo == 15'd0) : (r_slope_hi == 15'd0);
            n_side[e].zero = !r_dec[S_Y].nz || (r_y[e] >= YW'(SAT_LIM));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int e = 0; e < 2; e++) r_side[e] <= n_side[e];
        end
    end

    genvar ge;
    generate
        for (ge = 0; ge < 2; ge++) begin : g_exp_lane
            assign w_g[ge][0]    = MANT_W'(32'd1 << 30);
            assign w_side[ge][0] = r_side[ge];
            for (gk = 0; gk < LOG_FRAC; gk++) begin : g_cell
                eef_exp_cell #(.K(gk + 1)) u_cell (
                    .i_clk  (i_clk),
                    .i_en   (w_en),
                    .i_g    (w_g[ge][gk]),
                    .i_side (w_side[ge][gk]),
                    .o_g    (w_g[ge][gk+1]),
                    .o_side (w_side[ge][gk+1])
                );
            end
        end
    endgenerate

    // final rounding and mode select
    logic [GAIN_W-1:0] w_eg [2];
    logic [GAIN_W-1:0] n_res;
    logic [GAIN_W-1:0] r_res;
    t_dec              w_dec;

    always_comb begin
        w_dec = r_dec[EXP_END];
        for (int e = 0; e < 2; e++) begin
            if (w_side[e][LOG_FRAC].one) begin
                w_eg[e] = GAIN_ONE;
            end else if (w_side[e][LOG_FRAC].zero) begin
                w_eg[e] = '0;
            end else begin
                w_eg[e] = round_gain(w_g[e][LOG_FRAC], w_side[e][LOG_FRAC].n);
            end
        end
        case (r_mode)
            MODE_LOWPASS:  n_res = w_dec.lt_lo ? GAIN_ONE : w_eg[0];
            MODE_HIGHPASS: n_res = w_dec.gt_lo ? GAIN_ONE : w_eg[0];
            MODE_BANDPASS: n_res = w_dec.lt_lo ? w_eg[0] : (w_dec.gt_hi ? w_eg[1] : GAIN_ONE);
            MODE_REJECT: begin
                if (w_dec.lt_lo || w_dec.gt_hi) begin
                    n_res = GAIN_ONE;
                end else begin
                    n_res = (w_eg[1] < w_eg[0]) ? w_eg[1] : w_eg[0];
                end
            end
            default: n_res = GAIN_ONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_res <= n_res;
    end

    // output register with one skid entry
    logic              r_out_v;
    logic [GAIN_W-1:0] r_out;
    logic [GAIN_W-1:0] r_skid;
    logic              w_out_free;

    assign w_out_free = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_out_free) begin
                r_out_v  <= 1'b1;
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (w_out_free) begin
            r_out_v <= r_vld[S_RES];
            r_out   <= r_res;
        end else if (r_vld[S_RES]) begin
            r_skid_v <= 1'b1;
            r_skid   <= r_res;
        end
    end

    assign o_valid    = r_out_v;
    assign o_bin_gain = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/eef_checker.sv =====
// Port-level checks for eq_edge_filter_response, bound to the top level.
// Depends on eq_edge_filter_response ports only.
`timescale 1ns / 1ps
`default_nettype none

module eef_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [9:0]  i_bin_index,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [16:0] o_bin_gain
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_bin_gain))
        else $error("output transfer dropped while stalled");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_bin_index))
        else $error("input transfer changed while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_bin_gain <= 17'd65536)
        else $error("gain above unity");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output not idle after reset");

endmodule

bind eq_edge_filter_response eef_checker u_eef_checker (.*);

`default_nettype wire
